// ===== sv/tdm_pkg.sv =====
`default_nettype none

package tdm_pkg;

    // Field types
    typedef logic signed [15:0] angle_t;
    typedef logic signed [8:0]  speed_t;
    typedef logic signed [9:0]  mix_t;
    typedef logic [1:0]         dir_t;
    typedef logic [7:0]         duty_t;
    typedef logic [15:0]        tick_cnt_t;
    typedef logic [0:0]         cfg_index_t;
    typedef logic [15:0]        cfg_data_t;

    // Request command codes
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Motor direction codes
    localparam dir_t DIR_STOP = 2'd0;
    localparam dir_t DIR_FWD  = 2'd1;
    localparam dir_t DIR_REV  = 2'd2;

    // Register indexes and reset values
    localparam cfg_index_t REG_DEADZONE = 1'b0;
    localparam cfg_index_t REG_TIMEOUT  = 1'b1;
    localparam duty_t      DEADZONE_RESET = 8'd25;
    localparam tick_cnt_t  TIMEOUT_RESET  = 16'd500;

    // Speed range
    localparam mix_t      MIX_MAX   = 10'sd255;
    localparam mix_t      MIX_MIN   = -10'sd255;
    localparam speed_t    SPEED_MAX = 9'sd255;
    localparam speed_t    SPEED_MIN = -9'sd255;
    localparam tick_cnt_t TICK_SAT  = 16'hFFFF;

    // One tilt request as held in the input register
    typedef struct packed {
        logic   command;
        angle_t pitch_angle;
        angle_t roll_angle;
    } tilt_item_t;

endpackage

`default_nettype wire

// ===== sv/tdm_channels.sv =====
`default_nettype none

// Tilt request channel: packet or millisecond tick
interface tdm_tilt_if;
    import tdm_pkg::*;

    logic   valid;
    logic   ready;
    logic   command;
    angle_t pitch_angle;
    angle_t roll_angle;

    modport source (output valid, command, pitch_angle, roll_angle, input ready);
    modport sink   (input valid, command, pitch_angle, roll_angle, output ready);
endinterface

// Drive result channel: per-motor direction and duty
interface tdm_drive_if;
    import tdm_pkg::*;

    logic  valid;
    logic  ready;
    dir_t  left_dir;
    duty_t left_duty;
    dir_t  right_dir;
    duty_t right_duty;
    logic  link_lost;

    modport source (output valid, left_dir, left_duty, right_dir, right_duty, link_lost,
                    input ready);
    modport sink   (input valid, left_dir, left_duty, right_dir, right_duty, link_lost,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/tdm_angle_map.sv =====
`default_nettype none

// Clamp an angle to +/-ANGLE_LIMIT and scale it onto -255..255, truncating
// toward zero. The division by ANGLE_LIMIT is a multiply by a rounded-up
// reciprocal; the shift is wide enough that the quotient is exact for every
// magnitude in range.
module tdm_angle_map #(
    parameter int ANGLE_LIMIT = 5760
) (
    input  tdm_pkg::angle_t angle,
    output tdm_pkg::speed_t mapped
);
    import tdm_pkg::*;

    localparam int MAG_W = $clog2(ANGLE_LIMIT + 1);
    localparam int X_W   = MAG_W + 8;
    localparam int SHIFT = X_W + $clog2(ANGLE_LIMIT);
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + longint'(ANGLE_LIMIT) - 64'd1) / longint'(ANGLE_LIMIT);
    localparam int M_W   = $clog2(RECIP_FULL + 64'd1);
    localparam int P_W   = (X_W + M_W > SHIFT + 8) ? (X_W + M_W) : (SHIFT + 8);
    localparam logic [M_W-1:0] RECIP = M_W'(RECIP_FULL);
    localparam logic signed [16:0] LIM_POS = 17'(ANGLE_LIMIT);
    localparam logic signed [16:0] LIM_NEG = -17'(ANGLE_LIMIT);

    logic signed [16:0] wide;
    logic signed [16:0] clamped;
    logic signed [16:0] abs_val;
    logic [MAG_W-1:0]   mag;
    logic [X_W-1:0]     scaled;
    logic [P_W-1:0]     prod;
    duty_t              quot;
    speed_t             quot_s;

    // Clamp and take the magnitude
    always_comb
    begin
        wide = 17'(angle);
        if (wide > LIM_POS)
        begin
            clamped = LIM_POS;
        end
        else if (wide < LIM_NEG)
        begin
            clamped = LIM_NEG;
        end
        else
        begin
            clamped = wide;
        end
        abs_val = clamped[16] ? -clamped : clamped;
        mag     = abs_val[MAG_W-1:0];
    end

    // Scale by 255, then divide by the limit through the reciprocal
    assign scaled = {mag, 8'b0} - X_W'(mag);
    assign prod   = P_W'(scaled) * P_W'(RECIP);
    assign quot   = prod[SHIFT +: 8];
    assign quot_s = {1'b0, quot};

    // Restore the sign
    assign mapped = clamped[16] ? -quot_s : quot_s;

endmodule

`default_nettype wire

// ===== sv/tilt_differential_drive_mixer.sv =====
`default_nettype none

// Channel | Dir | Payload                                         | Accept
// --------+-----+-------------------------------------------------+-----------------
// tilt    | in  | command, pitch_angle, roll_angle                | valid && ready
// drive   | out | left_dir, left_duty, right_dir, right_duty,     | valid && ready
//         |     | link_lost                                       |
// cfg     | in  | cfg_index, cfg_wdata (deadzone, timeout_ticks)  | cfg_we
//
// One request per cycle sustained while drive takes results; a taken request
// passes the input register, then the result register, before its result is on drive.
// The mix path (clamp, reciprocal multiply, add, saturate, deadzone) sits
// between the input register and the result register.
// Reset clears the tick counter, both speeds and both valid flags, and
// loads deadzone 25 and timeout 500.
// A stalled drive holds its result; tilt stays ready while the input
// register can move forward.
module tilt_differential_drive_mixer #(
    parameter int ANGLE_LIMIT = 5760
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  tdm_pkg::cfg_index_t  cfg_index,
    input  tdm_pkg::cfg_data_t   cfg_wdata,
    tdm_tilt_if.sink             tilt,
    tdm_drive_if.source          drive
);
    import tdm_pkg::*;

    // Saturate a mixed sum to +/-255 and drop it inside the deadzone
    function automatic speed_t finish_speed(input mix_t sum, input duty_t dz);
        speed_t sat;
        speed_t neg;
        duty_t  mag;
        if (sum > MIX_MAX)
        begin
            sat = SPEED_MAX;
        end
        else if (sum < MIX_MIN)
        begin
            sat = SPEED_MIN;
        end
        else
        begin
            sat = sum[8:0];
        end
        neg = -sat;
        mag = sat[8] ? neg[7:0] : sat[7:0];
        return (mag < dz) ? 9'sd0 : sat;
    endfunction

    // Direction code for a speed
    function automatic dir_t speed_dir(input speed_t s);
        if (s == 9'sd0)
        begin
            return DIR_STOP;
        end
        return s[8] ? DIR_REV : DIR_FWD;
    endfunction

    // Duty (magnitude) for a speed
    function automatic duty_t speed_duty(input speed_t s);
        speed_t neg;
        neg = -s;
        return s[8] ? neg[7:0] : s[7:0];
    endfunction

    logic       item_valid_reg;
    tilt_item_t item_reg;
    logic       out_valid_reg;
    dir_t       left_dir_reg;
    duty_t      left_duty_reg;
    dir_t       right_dir_reg;
    duty_t      right_duty_reg;
    logic       lost_reg;
    duty_t      deadzone_reg;
    tick_cnt_t  timeout_reg;
    tick_cnt_t  cnt_reg;
    tick_cnt_t  cnt_next;
    speed_t     left_speed_reg;
    speed_t     left_speed_next;
    speed_t     right_speed_reg;
    speed_t     right_speed_next;

    logic       advance;
    logic       is_packet;
    logic       lost;
    speed_t     throttle;
    speed_t     steering;
    mix_t       left_sum;
    mix_t       right_sum;
    speed_t     left_fin;
    speed_t     right_fin;

    // Move the held request forward when the result register frees up
    assign advance    = item_valid_reg && (!out_valid_reg || drive.ready);
    assign tilt.ready = !item_valid_reg || advance;

    // Input register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (tilt.valid && tilt.ready)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    // Input register: payload
    always_ff @(posedge clk)
    begin
        if (tilt.valid && tilt.ready)
        begin
            item_reg.command     <= tilt.command;
            item_reg.pitch_angle <= tilt.pitch_angle;
            item_reg.roll_angle  <= tilt.roll_angle;
        end
    end

    // Map pitch to throttle and roll to steering
    tdm_angle_map #(
        .ANGLE_LIMIT (ANGLE_LIMIT)
    ) u_map_pitch (
        .angle  (item_reg.pitch_angle),
        .mapped (throttle)
    );

    tdm_angle_map #(
        .ANGLE_LIMIT (ANGLE_LIMIT)
    ) u_map_roll (
        .angle  (item_reg.roll_angle),
        .mapped (steering)
    );

    // Mix and finish both motor speeds
    assign left_sum  = mix_t'(throttle) + mix_t'(steering);
    assign right_sum = mix_t'(throttle) - mix_t'(steering);
    assign left_fin  = finish_speed(left_sum, deadzone_reg);
    assign right_fin = finish_speed(right_sum, deadzone_reg);

    // Advance the tick counter and decide link loss
    assign is_packet = (item_reg.command == CMD_PACKET);

    always_comb
    begin
        if (is_packet)
        begin
            cnt_next = '0;
        end
        else if (cnt_reg == TICK_SAT)
        begin
            cnt_next = cnt_reg;
        end
        else
        begin
            cnt_next = cnt_reg + 16'd1;
        end
        lost = (cnt_next > timeout_reg);

        if (lost)
        begin
            left_speed_next  = '0;
            right_speed_next = '0;
        end
        else if (is_packet)
        begin
            left_speed_next  = left_fin;
            right_speed_next = right_fin;
        end
        else
        begin
            left_speed_next  = left_speed_reg;
            right_speed_next = right_speed_reg;
        end
    end

    // Hold counter and speeds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            left_speed_reg  <= '0;
            right_speed_reg <= '0;
        end
        else if (advance)
        begin
            cnt_reg         <= cnt_next;
            left_speed_reg  <= left_speed_next;
            right_speed_reg <= right_speed_next;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg <= DEADZONE_RESET;
            timeout_reg  <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEADZONE: deadzone_reg <= cfg_wdata[7:0];
                REG_TIMEOUT:  timeout_reg  <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // Result register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (drive.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register: payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            left_dir_reg   <= speed_dir(left_speed_next);
            left_duty_reg  <= speed_duty(left_speed_next);
            right_dir_reg  <= speed_dir(right_speed_next);
            right_duty_reg <= speed_duty(right_speed_next);
            lost_reg       <= lost;
        end
    end

    assign drive.valid      = out_valid_reg;
    assign drive.left_dir   = left_dir_reg;
    assign drive.left_duty  = left_duty_reg;
    assign drive.right_dir  = right_dir_reg;
    assign drive.right_duty = right_duty_reg;
    assign drive.link_lost  = lost_reg;

`ifndef ASSERT_OFF
    // A lost link always reports both motors stopped
    a_lost_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && lost_reg |->
            left_dir_reg == DIR_STOP && right_dir_reg == DIR_STOP &&
            left_duty_reg == 8'd0 && right_duty_reg == 8'd0)
        else $error("link lost but a motor is still driven");

    // A stopped motor has zero duty, a driven one has nonzero duty
    a_dir_duty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((left_dir_reg == DIR_STOP) == (left_duty_reg == 8'd0)) &&
            ((right_dir_reg == DIR_STOP) == (right_duty_reg == 8'd0)))
        else $error("direction and duty disagree");

    // A packet clears the tick counter
    a_packet_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_packet |=> cnt_reg == '0)
        else $error("packet did not clear the tick counter");

    // A tick never lowers the tick counter
    a_tick_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !is_packet |=> cnt_reg >= $past(cnt_reg))
        else $error("tick lowered the tick counter");

    // A held request is not dropped while the result side stalls
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg && $stable(item_reg))
        else $error("held request lost during stall");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
    import tdm_pkg::*;

    localparam int TILT_RANGE = 5760;

    typedef struct packed {
        dir_t  left_dir;
        duty_t left_duty;
        dir_t  right_dir;
        duty_t right_duty;
        logic  link_lost;
    } drive_result_t;

    typedef enum logic {ROW_REQUEST, ROW_REGS} row_kind_t;

    typedef struct {
        row_kind_t     kind;
        logic          command;
        angle_t        pitch;
        angle_t        roll;
        logic          known;
        drive_result_t result;
        duty_t         deadzone_val;
        tick_cnt_t     timeout_val;
    } tilt_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_wdata;

    tdm_tilt_if  tilt_bus();
    tdm_drive_if drive_bus();

    tilt_differential_drive_mixer #(
        .ANGLE_LIMIT(TILT_RANGE)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .tilt     (tilt_bus),
        .drive    (drive_bus)
    );

    // Mixer state as the block should hold it
    duty_t     dz_reg      = DEADZONE_RESET;
    tick_cnt_t timeout_reg = TIMEOUT_RESET;
    tick_cnt_t idle_ticks  = '0;
    speed_t    left_speed_q  = '0;
    speed_t    right_speed_q = '0;

    drive_result_t pending_drive[$];
    tilt_row_t     directed_rows[$];

    int fail_count        = 0;
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;

    event hold_start;
    logic hold_active;

    // Free-running clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Clamp an angle and scale it onto the speed range, truncating toward zero
    function automatic int scale_angle(angle_t a);
        int v;
        int mag;
        v = a;
        if (v > TILT_RANGE)
            v = TILT_RANGE;
        if (v < -TILT_RANGE)
            v = -TILT_RANGE;
        mag = (v < 0) ? -v : v;
        mag = (mag * 255) / TILT_RANGE;
        return (v < 0) ? -mag : mag;
    endfunction

    // Saturate a mixed speed and drop it inside the deadzone
    function automatic speed_t shape_speed(int s);
        int mag;
        if (s > 255)
            s = 255;
        if (s < -255)
            s = -255;
        mag = (s < 0) ? -s : s;
        if (mag < int'(dz_reg))
            s = 0;
        return speed_t'(s);
    endfunction

    function automatic dir_t motor_dir(speed_t s);
        if (s > 0)
            return DIR_FWD;
        else if (s < 0)
            return DIR_REV;
        return DIR_STOP;
    endfunction

    // Advance the mixer state by one request and return the drive it yields
    function automatic drive_result_t predict_drive(logic cmd, angle_t pitch, angle_t roll);
        drive_result_t res;
        int throttle;
        int steer;
        logic lost;
        if (cmd == CMD_PACKET)
        begin
            throttle = scale_angle(pitch);
            steer = scale_angle(roll);
            left_speed_q = shape_speed(throttle + steer);
            right_speed_q = shape_speed(throttle - steer);
            idle_ticks = '0;
        end
        else if (idle_ticks != TICK_SAT)
        begin
            idle_ticks = idle_ticks + 1'b1;
        end
        lost = idle_ticks > timeout_reg;
        if (lost)
        begin
            left_speed_q = '0;
            right_speed_q = '0;
        end
        res.left_dir = motor_dir(left_speed_q);
        res.left_duty = duty_t'((left_speed_q < 0) ? -left_speed_q : left_speed_q);
        res.right_dir = motor_dir(right_speed_q);
        res.right_duty = duty_t'((right_speed_q < 0) ? -right_speed_q : right_speed_q);
        res.link_lost = lost;
        return res;
    endfunction

    // Mostly in-range angles, some full-range and some boundary values
    function automatic angle_t pick_angle();
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(7))
                    0: return angle_t'(-32768);
                    1: return angle_t'(32767);
                    2: return angle_t'(TILT_RANGE);
                    3: return angle_t'(-TILT_RANGE);
                    4: return angle_t'(TILT_RANGE + 1);
                    5: return angle_t'(-TILT_RANGE - 1);
                    6: return angle_t'(0);
                    default: return angle_t'(-1);
                endcase
            end
            1, 2: return angle_t'($urandom());
            default: return angle_t'(int'($urandom_range(2 * TILT_RANGE)) - TILT_RANGE);
        endcase
    endfunction

    function automatic void add_request(logic cmd, int pitch, int roll);
        tilt_row_t row;
        row = '{ROW_REQUEST, cmd, angle_t'(pitch), angle_t'(roll), 1'b0, '0, '0, '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_known(logic cmd, int pitch, int roll, dir_t ld, int lu,
                                      dir_t rd, int ru, logic lost);
        tilt_row_t row;
        drive_result_t res;
        res = '{ld, duty_t'(lu), rd, duty_t'(ru), lost};
        row = '{ROW_REQUEST, cmd, angle_t'(pitch), angle_t'(roll), 1'b1, res, '0, '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_regs(int dz, int to);
        tilt_row_t row;
        row = '{ROW_REGS, CMD_PACKET, '0, '0, 1'b0, '0, duty_t'(dz), tick_cnt_t'(to)};
        directed_rows.push_back(row);
    endfunction

    // Offer one request, hold it until taken, then record its expected drive
    task automatic send_tilt(input logic cmd, input angle_t pitch, input angle_t roll,
                             input logic known = 1'b0, input drive_result_t known_res = '0);
        drive_result_t want;
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            tilt_bus.valid <= 1'b0;
            @(posedge clk);
        end
        tilt_bus.valid       <= 1'b1;
        tilt_bus.command     <= cmd;
        tilt_bus.pitch_angle <= pitch;
        tilt_bus.roll_angle  <= roll;
        @(posedge clk);
        while (!tilt_bus.ready)
            @(posedge clk);
        want = predict_drive(cmd, pitch, roll);
        if (known)
            want = known_res;
        pending_drive.push_back(want);
    endtask

    // Stop offering and wait until every expected drive has come back
    task automatic drain_drive();
        tilt_bus.valid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Drain, then write both registers
    task automatic write_regs(input duty_t dz, input tick_cnt_t to);
        drain_drive();
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEADZONE;
        cfg_wdata <= cfg_data_t'(dz);
        @(posedge clk);
        cfg_index <= REG_TIMEOUT;
        cfg_wdata <= cfg_data_t'(to);
        @(posedge clk);
        cfg_we <= 1'b0;
        dz_reg = dz;
        timeout_reg = to;
    endtask

    // Compare one taken drive with the oldest expectation
    task automatic check_drive();
        drive_result_t want;
        drive_result_t got;
        got = '{drive_bus.left_dir, drive_bus.left_duty, drive_bus.right_dir,
                drive_bus.right_duty, drive_bus.link_lost};
        if (pending_drive.size() == 0)
        begin
            if (fail_count < 10)
                $display("drive with nothing expected: L %0d/%0d R %0d/%0d lost %0b",
                         got.left_dir, got.left_duty, got.right_dir, got.right_duty,
                         got.link_lost);
            fail_count++;
        end
        else
        begin
            want = pending_drive.pop_front();
            if (got !== want)
            begin
                if (fail_count < 10)
                begin
                    $display("drive mismatch: want L %0d/%0d R %0d/%0d lost %0b",
                             want.left_dir, want.left_duty, want.right_dir,
                             want.right_duty, want.link_lost);
                    $display("                got  L %0d/%0d R %0d/%0d lost %0b",
                             got.left_dir, got.left_duty, got.right_dir,
                             got.right_duty, got.link_lost);
                end
                fail_count++;
            end
        end
    endtask

    // Hold off the receiver for a long stretch, counted here
    initial
    begin
        hold_active = 1'b0;
        forever
        begin
            @(hold_start);
            hold_active = 1'b1;
            repeat (60) @(posedge clk);
            hold_active = 1'b0;
        end
    end

    // Take drives, then pick ready for the next cycle
    always @(posedge clk)
    begin
        if (drive_bus.valid && drive_bus.ready)
            check_drive();
        if (hold_active)
            drive_bus.ready <= 1'b0;
        else
            drive_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Stimulus
    initial
    begin
        tilt_row_t row;
        int phase;
        int sent;
        int burst;
        int burst_max;
        logic stall_done;
        duty_t phase_dz;
        tick_cnt_t phase_to;

        stall_done = 1'b0;
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_DEADZONE;
        cfg_wdata <= '0;
        tilt_bus.valid <= 1'b0;
        tilt_bus.command <= CMD_PACKET;
        tilt_bus.pitch_angle <= '0;
        tilt_bus.roll_angle <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests: extremes, deadzone, timeout and saturation edges
        add_known(CMD_TICK, 0, 0, DIR_STOP, 0, DIR_STOP, 0, 1'b0);
        add_known(CMD_PACKET, TILT_RANGE, 0, DIR_FWD, 255, DIR_FWD, 255, 1'b0);
        add_known(CMD_PACKET, 32767, 32767, DIR_FWD, 255, DIR_STOP, 0, 1'b0);
        add_known(CMD_PACKET, -32768, -32768, DIR_REV, 255, DIR_STOP, 0, 1'b0);
        add_known(CMD_PACKET, 0, 32767, DIR_FWD, 255, DIR_REV, 255, 1'b0);
        add_known(CMD_PACKET, 0, -32768, DIR_REV, 255, DIR_FWD, 255, 1'b0);
        add_known(CMD_PACKET, 100, 0, DIR_STOP, 0, DIR_STOP, 0, 1'b0);
        add_request(CMD_PACKET, 1234, -567);
        add_request(CMD_TICK, -32768, 32767);
        add_request(CMD_PACKET, -TILT_RANGE - 1, TILT_RANGE + 1);
        add_regs(0, 500);
        add_request(CMD_PACKET, 100, 0);
        add_known(CMD_PACKET, -1, 1, DIR_STOP, 0, DIR_STOP, 0, 1'b0);
        add_regs(0, 2);
        add_known(CMD_PACKET, TILT_RANGE, 0, DIR_FWD, 255, DIR_FWD, 255, 1'b0);
        add_request(CMD_TICK, 0, 0);
        add_request(CMD_TICK, 0, 0);
        add_known(CMD_TICK, 0, 0, DIR_STOP, 0, DIR_STOP, 0, 1'b1);
        add_known(CMD_TICK, 32767, -1, DIR_STOP, 0, DIR_STOP, 0, 1'b1);
        add_request(CMD_PACKET, 2880, 2880);
        add_regs(0, 0);
        add_known(CMD_TICK, 0, 0, DIR_STOP, 0, DIR_STOP, 0, 1'b1);
        add_request(CMD_PACKET, -3000, 1500);
        add_regs(255, 65535);
        add_known(CMD_PACKET, TILT_RANGE, -TILT_RANGE, DIR_STOP, 0, DIR_FWD, 255, 1'b0);
        add_request(CMD_PACKET, 5000, 0);

        sender_idle_pct = 28;
        receiver_idle_pct = 53;
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_REGS)
                write_regs(row.deadzone_val, row.timeout_val);
            else
                send_tilt(row.command, row.pitch, row.roll, row.known, row.result);
        end

        // Random phases: packet followed by a burst of ticks, plus loose requests
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    sender_idle_pct = 28;
                    receiver_idle_pct = 53;
                end
                1:
                begin
                    sender_idle_pct = 53;
                    receiver_idle_pct = 28;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            case (phase)
                0:
                begin
                    phase_dz = 8'd0;
                    phase_to = 16'd0;
                end
                1:
                begin
                    phase_dz = 8'd255;
                    phase_to = 16'd5;
                end
                2:
                begin
                    phase_dz = DEADZONE_RESET;
                    phase_to = 16'hFFFF;
                end
                3:
                begin
                    phase_dz = duty_t'($urandom_range(255));
                    phase_to = tick_cnt_t'($urandom_range(40));
                end
                4:
                begin
                    phase_dz = 8'd1;
                    phase_to = 16'd1;
                end
                default:
                begin
                    phase_dz = 8'd128;
                    phase_to = 16'd30;
                end
            endcase
            write_regs(phase_dz, phase_to);
            burst_max = (timeout_reg <= 60) ? int'(timeout_reg) + 3 : 12;
            sent = 0;
            while (sent < 325)
            begin
                // Hold off the receiver for a long stretch while requests keep coming
                if (phase == 0 && sent >= 40 && !stall_done)
                begin
                    -> hold_start;
                    stall_done = 1'b1;
                end
                if ($urandom_range(9) < 7)
                begin
                    send_tilt(CMD_PACKET, pick_angle(), pick_angle());
                    burst = $urandom_range(burst_max);
                    repeat (burst)
                        send_tilt(CMD_TICK, angle_t'($urandom()), angle_t'($urandom()));
                    sent += 1 + burst;
                end
                else
                begin
                    send_tilt(logic'($urandom_range(1)), pick_angle(), pick_angle());
                    sent++;
                end
            end
        end

        drain_drive();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_drive.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Drop the run if it hangs
    initial
    begin
        #4000000;
        $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire
